// ===== rtl/lswc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lswc_pkg;

    localparam int NUM_EDGES = 4;

    localparam logic [1:0] REG_XMIN = 2'd0;
    localparam logic [1:0] REG_YMIN = 2'd1;
    localparam logic [1:0] REG_XMAX = 2'd2;
    localparam logic [1:0] REG_YMAX = 2'd3;

    // per edge status, carried down the divider chain
    typedef struct packed {
        logic pz;
        logic pneg;
        logic qneg;
        logic qz;
        logic sat;
    } lswc_edge_t;

    localparam int EDGE_W = $bits(lswc_edge_t);

endpackage
`default_nettype wire

// ===== rtl/lswc_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lswc_prep
    import lswc_pkg::*;
#(
    parameter int CW = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 v_in,
    input  wire logic signed [CW-1:0] sx,
    input  wire logic signed [CW-1:0] sy,
    input  wire logic signed [CW-1:0] ex,
    input  wire logic signed [CW-1:0] ey,
    input  wire logic signed [CW-1:0] xmin,
    input  wire logic signed [CW-1:0] ymin,
    input  wire logic signed [CW-1:0] xmax,
    input  wire logic signed [CW-1:0] ymax,
    output logic                      v_out,
    output logic [CW-1:0]             aq [NUM_EDGES],
    output logic [CW-1:0]             ap [NUM_EDGES],
    output lswc_edge_t                flags [NUM_EDGES],
    output logic signed [CW-1:0]      x1,
    output logic signed [CW-1:0]      y1,
    output logic signed [CW:0]        dx,
    output logic signed [CW:0]        dy
);

    logic                 v1_reg;
    logic signed [CW:0]   dx_reg, dy_reg;
    logic signed [CW:0]   q_reg [NUM_EDGES];
    logic signed [CW-1:0] x1_reg, y1_reg;

    logic                 v2_reg;
    logic [CW-1:0]        aq_next [NUM_EDGES], aq_reg [NUM_EDGES];
    logic [CW-1:0]        ap_next [NUM_EDGES], ap_reg [NUM_EDGES];
    lswc_edge_t           fl_next [NUM_EDGES], fl_reg [NUM_EDGES];
    logic signed [CW-1:0] x1b_reg, y1b_reg;
    logic signed [CW:0]   dxb_reg, dyb_reg;

    // differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= {ex[CW-1], ex} - {sx[CW-1], sx};
            dy_reg   <= {ey[CW-1], ey} - {sy[CW-1], sy};
            q_reg[0] <= {sx[CW-1], sx} - {xmin[CW-1], xmin};
            q_reg[1] <= {xmax[CW-1], xmax} - {sx[CW-1], sx};
            q_reg[2] <= {sy[CW-1], sy} - {ymin[CW-1], ymin};
            q_reg[3] <= {ymax[CW-1], ymax} - {sy[CW-1], sy};
            x1_reg   <= sx;
            y1_reg   <= sy;
        end
    end

    // magnitudes and edge status
    always_comb
    begin
        logic signed [CW:0] d;
        logic signed [CW:0] ad;
        logic signed [CW:0] aqw;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            d   = (e < 2) ? dx_reg : dy_reg;
            ad  = d[CW] ? -d : d;
            aqw = q_reg[e][CW] ? -q_reg[e] : q_reg[e];
            ap_next[e] = ad[CW-1:0];
            aq_next[e] = aqw[CW-1:0];
            fl_next[e].pz   = (d == '0);
            fl_next[e].pneg = (e == 0 || e == 2) ? (!d[CW] && d != '0) : d[CW];
            fl_next[e].qneg = q_reg[e][CW];
            fl_next[e].qz   = (q_reg[e] == '0);
            fl_next[e].sat  = {1'b0, aqw[CW-1:0]} >= {ad[CW-1:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aq_reg  <= aq_next;
            ap_reg  <= ap_next;
            fl_reg  <= fl_next;
            x1b_reg <= x1_reg;
            y1b_reg <= y1_reg;
            dxb_reg <= dx_reg;
            dyb_reg <= dy_reg;
        end
    end

    assign v_out = v2_reg;
    assign aq    = aq_reg;
    assign ap    = ap_reg;
    assign flags = fl_reg;
    assign x1    = x1b_reg;
    assign y1    = y1b_reg;
    assign dx    = dxb_reg;
    assign dy    = dyb_reg;

endmodule
`default_nettype wire

// ===== rtl/lswc_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lswc_div_cell
    import lswc_pkg::*;
#(
    parameter int CW = 32,
    parameter int FW = 24,
    parameter int SW = 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          v_in,
    input  wire logic [CW:0]   rem_in [NUM_EDGES],
    input  wire logic [CW-1:0] ap_in  [NUM_EDGES],
    input  wire logic [FW:0]   quo_in [NUM_EDGES],
    input  wire logic [SW-1:0] side_in,
    output logic               v_out,
    output logic [CW:0]        rem_out [NUM_EDGES],
    output logic [CW-1:0]      ap_out  [NUM_EDGES],
    output logic [FW:0]        quo_out [NUM_EDGES],
    output logic [SW-1:0]      side_out
);

    logic          v_reg;
    logic [CW:0]   rem_next [NUM_EDGES], rem_reg [NUM_EDGES];
    logic [FW:0]   quo_next [NUM_EDGES], quo_reg [NUM_EDGES];
    logic [CW-1:0] ap_reg [NUM_EDGES];
    logic [SW-1:0] side_reg;

    // one restoring step per edge
    always_comb
    begin
        logic          ge;
        logic [CW:0]   r2;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            ge          = rem_in[e] >= {1'b0, ap_in[e]};
            r2          = ge ? rem_in[e] - {1'b0, ap_in[e]} : rem_in[e];
            rem_next[e] = {r2[CW-1:0], 1'b0};
            quo_next[e] = {quo_in[e][FW-1:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            ap_reg   <= ap_in;
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign ap_out   = ap_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// ===== rtl/lswc_finish.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lswc_finish
    import lswc_pkg::*;
#(
    parameter int CW = 32,
    parameter int FW = 24
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 v_in,
    input  wire logic [FW:0]          quo [NUM_EDGES],
    input  wire lswc_edge_t           flags [NUM_EDGES],
    input  wire logic signed [CW-1:0] x1,
    input  wire logic signed [CW-1:0] y1,
    input  wire logic signed [CW:0]   dx,
    input  wire logic signed [CW:0]   dy,
    output logic                      out_valid,
    output logic signed [CW-1:0]      out_start_x,
    output logic signed [CW-1:0]      out_start_y,
    output logic signed [CW-1:0]      out_end_x,
    output logic signed [CW-1:0]      out_end_y,
    output logic                      visible
);

    localparam logic [FW:0] U_ONE = {1'b1, {FW{1'b0}}};
    localparam logic [FW:0] U_MAX = '1;

    // combine
    logic                 u1_lt, acc_next;
    logic [FW:0]          u1_next, u2_next;
    logic                 v1_reg, acc_reg;
    logic [FW:0]          u1_reg, u2_reg;
    logic [CW-1:0]        ax_reg, ay_reg;
    logic                 sx_reg, sy_reg;
    logic signed [CW-1:0] x1_reg, y1_reg;

    always_comb
    begin
        logic [FW:0] r;
        logic        rej;
        u1_next = '0;
        u2_next = U_ONE;
        rej     = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            r = flags[e].qz ? '0 : (flags[e].sat ? U_MAX : quo[e]);
            if (flags[e].pz)
            begin
                rej = rej | flags[e].qneg;
            end
            else if (flags[e].pneg)
            begin
                if (flags[e].qneg && r > u1_next)
                begin
                    u1_next = r;
                end
            end
            else
            begin
                if (flags[e].qneg && !flags[e].qz)
                begin
                    rej = 1'b1;
                end
                else if (r < u2_next)
                begin
                    u2_next = r;
                end
            end
        end
        u1_lt    = (u1_next <= u2_next);
        acc_next = !rej && u1_lt;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
            u1_reg  <= u1_next;
            u2_reg  <= u2_next;
            ax_reg  <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
            ay_reg  <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
            sx_reg  <= dx[CW];
            sy_reg  <= dy[CW];
            x1_reg  <= x1;
            y1_reg  <= y1;
        end
    end

    // scale
    logic [CW+FW:0]       p_sx, p_sy, p_ex, p_ey;
    logic                 v2_reg, acc2_reg, sx2_reg, sy2_reg;
    logic [CW-1:0]        m_sx_reg, m_sy_reg, m_ex_reg, m_ey_reg;
    logic signed [CW-1:0] x2_reg, y2_reg;

    assign p_sx = (CW+FW+1)'(ax_reg) * (CW+FW+1)'(u1_reg);
    assign p_sy = (CW+FW+1)'(ay_reg) * (CW+FW+1)'(u1_reg);
    assign p_ex = (CW+FW+1)'(ax_reg) * (CW+FW+1)'(u2_reg);
    assign p_ey = (CW+FW+1)'(ay_reg) * (CW+FW+1)'(u2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc2_reg <= acc_reg;
            sx2_reg  <= sx_reg;
            sy2_reg  <= sy_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            m_sx_reg <= p_sx[CW+FW-1:FW];
            m_sy_reg <= p_sy[CW+FW-1:FW];
            m_ex_reg <= p_ex[CW+FW-1:FW];
            m_ey_reg <= p_ey[CW+FW-1:FW];
        end
    end

    // endpoints
    function automatic logic [CW-1:0] step_to(
        input logic [CW-1:0] base,
        input logic          neg,
        input logic [CW-1:0] m
    );
        logic [CW:0] s;
        s = neg ? {1'b0, base} - {1'b0, m} : {1'b0, base} + {1'b0, m};
        return s[CW-1:0];
    endfunction

    logic                 ov_reg, vis_reg;
    logic signed [CW-1:0] osx_reg, osy_reg, oex_reg, oey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            ov_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg <= acc2_reg;
            osx_reg <= acc2_reg ? step_to(x2_reg, sx2_reg, m_sx_reg) : '0;
            osy_reg <= acc2_reg ? step_to(y2_reg, sy2_reg, m_sy_reg) : '0;
            oex_reg <= acc2_reg ? step_to(x2_reg, sx2_reg, m_ex_reg) : '0;
            oey_reg <= acc2_reg ? step_to(y2_reg, sy2_reg, m_ey_reg) : '0;
        end
    end

    assign out_valid   = ov_reg;
    assign visible     = vis_reg;
    assign out_start_x = osx_reg;
    assign out_start_y = osy_reg;
    assign out_end_x   = oex_reg;
    assign out_end_y   = oey_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (out_start_x == '0 && out_start_y == '0
            && out_end_x == '0 && out_end_y == '0))
        else $error("rejected beat carries coordinates");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && acc_reg) |-> (u1_reg <= u2_reg))
        else $error("accepted segment with entry past exit");

    a_exit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (u2_reg <= U_ONE))
        else $error("exit parameter above one");

endmodule
`default_nettype wire

// ===== rtl/line_segment_window_clip_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | signals                                  | direction
// input   | in_valid, in_ready, start_x/y, end_x/y   | in
// output  | out_valid, out_ready, out_*, visible     | out
// config  | cfg_we, cfg_index, cfg_data              | in
// one beat accepted per cycle while no output beat is held
// the divider chain produces one quotient bit per cell
// reset clears all valid bits and loads the widest window
// a held output beat stalls the whole pipeline; in_ready drops with it
module line_segment_window_clip_unit
    import lswc_pkg::*;
#(
    parameter int COORD_WIDTH         = 32,
    parameter int PARAM_FRACTION_BITS = 24
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      out_start_x,
    output logic signed [COORD_WIDTH-1:0]      out_start_y,
    output logic signed [COORD_WIDTH-1:0]      out_end_x,
    output logic signed [COORD_WIDTH-1:0]      out_end_y,
    output logic                               visible,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [COORD_WIDTH-1:0]        cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int FW = PARAM_FRACTION_BITS;
    localparam int NC = FW + 1;
    localparam int SW = NUM_EDGES * EDGE_W + 4 * CW + 2;

    logic                 adv;
    logic signed [CW-1:0] xmin_reg, ymin_reg, xmax_reg, ymax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmin_reg <= {1'b1, {(CW-1){1'b0}}};
            ymin_reg <= {1'b1, {(CW-1){1'b0}}};
            xmax_reg <= {1'b0, {(CW-1){1'b1}}};
            ymax_reg <= {1'b0, {(CW-1){1'b1}}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_XMIN: xmin_reg <= cfg_data;
                REG_YMIN: ymin_reg <= cfg_data;
                REG_XMAX: xmax_reg <= cfg_data;
                REG_YMAX: ymax_reg <= cfg_data;
                default:  xmin_reg <= xmin_reg;
            endcase
        end
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic                 pv;
    logic [CW-1:0]        p_aq [NUM_EDGES];
    logic [CW-1:0]        p_ap [NUM_EDGES];
    lswc_edge_t           p_fl [NUM_EDGES];
    logic signed [CW-1:0] p_x1, p_y1;
    logic signed [CW:0]   p_dx, p_dy;

    lswc_prep #(.CW(CW)) u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .v_in  (in_valid && in_ready),
        .sx    (start_x),
        .sy    (start_y),
        .ex    (end_x),
        .ey    (end_y),
        .xmin  (xmin_reg),
        .ymin  (ymin_reg),
        .xmax  (xmax_reg),
        .ymax  (ymax_reg),
        .v_out (pv),
        .aq    (p_aq),
        .ap    (p_ap),
        .flags (p_fl),
        .x1    (p_x1),
        .y1    (p_y1),
        .dx    (p_dx),
        .dy    (p_dy)
    );

    logic          c_v    [NC+1];
    logic [CW:0]   c_rem  [NC+1][NUM_EDGES];
    logic [CW-1:0] c_ap   [NC+1][NUM_EDGES];
    logic [FW:0]   c_quo  [NC+1][NUM_EDGES];
    logic [SW-1:0] c_side [NC+1];

    always_comb
    begin
        c_v[0]    = pv;
        c_side[0] = {p_fl[0], p_fl[1], p_fl[2], p_fl[3], p_x1, p_y1, p_dx, p_dy};
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            c_rem[0][e] = {1'b0, p_aq[e]};
            c_ap[0][e]  = p_ap[e];
            c_quo[0][e] = '0;
        end
    end

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        lswc_div_cell #(.CW(CW), .FW(FW), .SW(SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .v_in     (c_v[i]),
            .rem_in   (c_rem[i]),
            .ap_in    (c_ap[i]),
            .quo_in   (c_quo[i]),
            .side_in  (c_side[i]),
            .v_out    (c_v[i+1]),
            .rem_out  (c_rem[i+1]),
            .ap_out   (c_ap[i+1]),
            .quo_out  (c_quo[i+1]),
            .side_out (c_side[i+1])
        );
    end

    lswc_edge_t           f_fl [NUM_EDGES];
    logic signed [CW-1:0] f_x1, f_y1;
    logic signed [CW:0]   f_dx, f_dy;

    assign {f_fl[0], f_fl[1], f_fl[2], f_fl[3], f_x1, f_y1, f_dx, f_dy} = c_side[NC];

    lswc_finish #(.CW(CW), .FW(FW)) u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .v_in        (c_v[NC]),
        .quo         (c_quo[NC]),
        .flags       (f_fl),
        .x1          (f_x1),
        .y1          (f_y1),
        .dx          (f_dx),
        .dy          (f_dy),
        .out_valid   (out_valid),
        .out_start_x (out_start_x),
        .out_start_y (out_start_y),
        .out_end_x   (out_end_x),
        .out_end_y   (out_end_y),
        .visible     (visible)
    );

endmodule
`default_nettype wire
